// ===== design/clat_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clat_pkg
// Shared types and codes for the console link awake tracker and transmit gate.
// ----------------------------------------------------------------------------
package clat_pkg;

  typedef enum logic [1:0] {
    MODE_SAMPLE = 2'd0,
    MODE_WAKE   = 2'd1,
    MODE_WRITE  = 2'd2,
    MODE_BATCH  = 2'd3
  } clat_mode_t;

  localparam logic [1:0] EDGE_NONE  = 2'd0;
  localparam logic [1:0] EDGE_WAKE  = 2'd1;
  localparam logic [1:0] EDGE_SLEEP = 2'd2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_AWAKE_HIGH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLEEP_AFTER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TX_HOLD = 2'd2;

  localparam logic [15:0] AWAKE_HIGH_RESET = 16'd5000;
  localparam logic [19:0] SLEEP_AFTER_RESET = 20'd5000;
  localparam logic [15:0] TX_HOLD_RESET = 16'd2000;

  localparam logic [1:0] LOW_COUNT_MAX = 2'd3;

  typedef struct packed {
    clat_mode_t  mode;
    logic [31:0] now_ms;
    logic        real_bytes;
    logic        rx_level;
    logic [31:0] hold_ms;
    logic [11:0] write_length;
    logic        batch_hold_on;
  } clat_item_t;

  typedef struct packed {
    logic       awake;
    logic       line_high;
    logic       tx_attached;
    logic [1:0] edge_res;
    logic       write_accepted;
  } clat_result_t;

endpackage

// ===== design/clat_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clat_core
// Link state registers, configuration registers and the single-pass update
// that turns one request into the next state and its result.
// ----------------------------------------------------------------------------
module clat_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [clat_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [clat_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               item_fire,
  input  clat_pkg::clat_item_t               item,
  output clat_pkg::clat_result_t             result
);
  import clat_pkg::*;

  logic [15:0] high_idle_ms;
  logic [19:0] sleep_limit_ms;
  logic [15:0] tx_linger_ms;

  logic [31:0] last_activity_time, last_activity_time_next;
  logic        activity_valid, activity_valid_next;
  logic [31:0] high_since_time, high_since_time_next;
  logic [1:0]  low_sample_count, low_sample_count_next;
  logic        line_powered, line_powered_next;
  logic        awake_flag, awake_flag_next;
  logic        attached_flag, attached_flag_next;
  logic        batch_held, batch_held_next;
  logic [31:0] hold_deadline, hold_deadline_next;
  logic [31:0] wake_deadline, wake_deadline_next;

  logic [31:0] now;
  logic [31:0] high_age;
  logic [31:0] act_age;
  logic [31:0] wake_diff;
  logic [31:0] hold_diff;
  logic [31:0] wake_until;
  logic [31:0] write_deadline;
  logic        activity_now;
  logic        now_awake;
  logic        wake_running;
  logic        wake_done;
  logic        hold_ended;
  logic [1:0]  edge_code;
  logic        accepted;

  assign now            = item.now_ms;
  assign high_age       = now - high_since_time;
  assign wake_diff      = now - wake_deadline;
  assign hold_diff      = now - hold_deadline;
  assign wake_until     = now + item.hold_ms;
  assign write_deadline = now + {16'd0, tx_linger_ms};

  // Signed wrap-safe compares reduce to the sign bit of the difference.
  assign wake_running = (wake_deadline != 32'd0) && wake_diff[31];
  assign wake_done    = (wake_deadline != 32'd0) && !wake_diff[31];

  assign activity_now = item.rx_level && (item.real_bytes ||
                        (high_since_time != 32'd0 && high_age >= {16'd0, high_idle_ms}));

  assign act_age = activity_now ? 32'd0 : (now - last_activity_time);
  assign now_awake = (activity_now || activity_valid) && (act_age < {12'd0, sleep_limit_ms});

  always_comb begin
    last_activity_time_next = last_activity_time;
    activity_valid_next     = activity_valid;
    high_since_time_next    = high_since_time;
    low_sample_count_next   = low_sample_count;
    line_powered_next       = line_powered;
    awake_flag_next         = awake_flag;
    attached_flag_next      = attached_flag;
    batch_held_next         = batch_held;
    hold_deadline_next      = hold_deadline;
    wake_deadline_next      = wake_deadline;
    edge_code               = EDGE_NONE;
    accepted                = 1'b0;
    hold_ended              = 1'b0;

    case (item.mode)
      MODE_SAMPLE: begin
        if (activity_now) begin
          last_activity_time_next = now;
          activity_valid_next     = 1'b1;
        end
        if (item.rx_level && item.real_bytes) begin
          high_since_time_next = 32'd0;
        end else if (item.rx_level) begin
          if (high_since_time == 32'd0) begin
            high_since_time_next = (now == 32'd0) ? 32'd1 : now;
          end
        end else begin
          high_since_time_next = 32'd0;
        end

        if (item.real_bytes || item.rx_level) begin
          low_sample_count_next = 2'd0;
          line_powered_next     = 1'b1;
        end else if (low_sample_count != LOW_COUNT_MAX) begin
          low_sample_count_next = low_sample_count + 2'd1;
          if (low_sample_count + 2'd1 == LOW_COUNT_MAX) begin
            line_powered_next = 1'b0;
          end
        end

        if (now_awake != awake_flag) begin
          awake_flag_next = now_awake;
          edge_code       = now_awake ? EDGE_WAKE : EDGE_SLEEP;
          if (!now_awake && !wake_running) begin
            attached_flag_next = 1'b0;
          end
        end

        if (wake_done) begin
          wake_deadline_next = 32'd0;
        end

        hold_ended = !wake_running &&
                     ((!batch_held && hold_diff != 32'd0 && !hold_diff[31]) ||
                      !line_powered_next);
        if (hold_ended) begin
          attached_flag_next = 1'b0;
        end
      end
      MODE_WAKE: begin
        wake_deadline_next = (wake_until == 32'd0) ? 32'd1 : wake_until;
        hold_deadline_next = (wake_until == 32'd0) ? 32'd1 : wake_until;
        attached_flag_next = 1'b1;
      end
      MODE_WRITE: begin
        if (awake_flag && line_powered && item.write_length != 12'd0) begin
          hold_deadline_next = write_deadline;
          attached_flag_next = 1'b1;
          accepted           = 1'b1;
        end
      end
      default: begin
        batch_held_next = item.batch_hold_on;
        if (!item.batch_hold_on) begin
          hold_deadline_next = write_deadline;
        end
      end
    endcase
  end

  always_comb begin
    result.awake          = awake_flag_next;
    result.line_high      = line_powered_next;
    result.tx_attached    = attached_flag_next;
    result.edge_res       = edge_code;
    result.write_accepted = accepted;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      high_idle_ms   <= AWAKE_HIGH_RESET;
      sleep_limit_ms <= SLEEP_AFTER_RESET;
      tx_linger_ms   <= TX_HOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_AWAKE_HIGH:  high_idle_ms   <= cfg_data[15:0];
        CFG_SLEEP_AFTER: sleep_limit_ms <= cfg_data;
        CFG_TX_HOLD:     tx_linger_ms   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_activity_time <= 32'd0;
      activity_valid     <= 1'b0;
      high_since_time    <= 32'd0;
      low_sample_count   <= LOW_COUNT_MAX;
      line_powered       <= 1'b0;
      awake_flag         <= 1'b0;
      attached_flag      <= 1'b0;
      batch_held         <= 1'b0;
      hold_deadline      <= 32'd0;
      wake_deadline      <= 32'd0;
    end else if (item_fire) begin
      last_activity_time <= last_activity_time_next;
      activity_valid     <= activity_valid_next;
      high_since_time    <= high_since_time_next;
      low_sample_count   <= low_sample_count_next;
      line_powered       <= line_powered_next;
      awake_flag         <= awake_flag_next;
      attached_flag      <= attached_flag_next;
      batch_held         <= batch_held_next;
      hold_deadline      <= hold_deadline_next;
      wake_deadline      <= wake_deadline_next;
    end
  end

endmodule

// ===== design/console_link_awake_and_tx_gate.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// console_link_awake_and_tx_gate
// Tracks whether a serial console partner is powered and awake and gates the
// transmit pin from wake, write, batch-hold and sample requests.
// ----------------------------------------------------------------------------
// Every input request gives exactly one result. The block takes one request
// per clock unless in_stall is high: an accepted request is captured in an
// input register, the link state update and the result are computed in one
// pass of compare and subtract logic, and the result is then loaded into an
// output register when that register is free or being taken, where it is
// offered. The result sits in the output register until taken. The
// input side keeps accepting while a result waits, as long as the input
// register is empty or moves on into the output register this cycle, so two
// requests can be held against a stalled receiver before the input stalls.
// Configuration writes are taken at any edge with cfg_we high and rst low.
module console_link_awake_and_tx_gate (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [clat_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [clat_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      mode,
  input  logic [31:0]                     now_ms,
  input  logic                            real_bytes,
  input  logic                            rx_level,
  input  logic [31:0]                     hold_ms,
  input  logic [11:0]                     write_length,
  input  logic                            batch_hold_on,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            awake,
  output logic                            line_high,
  output logic                            tx_attached,
  output logic [1:0]                      edge_res,
  output logic                            write_accepted
);
  import clat_pkg::*;

  logic         s1_valid;
  clat_item_t   s1_item;
  logic         s1_advance;
  logic         in_fire;
  clat_result_t core_result;
  clat_result_t out_result;

  assign s1_advance = !out_valid || !out_stall;
  assign in_stall   = s1_valid && !s1_advance;
  assign in_fire    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_fire || (s1_valid && !s1_advance);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item.mode          <= clat_mode_t'(mode);
      s1_item.now_ms        <= now_ms;
      s1_item.real_bytes    <= real_bytes;
      s1_item.rx_level      <= rx_level;
      s1_item.hold_ms       <= hold_ms;
      s1_item.write_length  <= write_length;
      s1_item.batch_hold_on <= batch_hold_on;
    end
  end

  clat_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item_fire (s1_valid && s1_advance),
    .item      (s1_item),
    .result    (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= (s1_valid && s1_advance) || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_advance) begin
      out_result <= core_result;
    end
  end

  assign awake          = out_result.awake;
  assign line_high      = out_result.line_high;
  assign tx_attached    = out_result.tx_attached;
  assign edge_res       = out_result.edge_res;
  assign write_accepted = out_result.write_accepted;

endmodule

// ===== design/clat_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clat_checker
// Port-level checks on the results of the console link awake tracker.
// ----------------------------------------------------------------------------
module clat_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic       awake,
  input logic       line_high,
  input logic       tx_attached,
  input logic [1:0] edge_res,
  input logic       write_accepted
);
  import clat_pkg::*;

  // A result held back by the receiver must stay offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_wake_edge: assert property (@(posedge clk) disable iff (rst)
    out_valid && edge_res == EDGE_WAKE |-> awake)
    else $error("wake edge reported while asleep");

  a_sleep_edge: assert property (@(posedge clk) disable iff (rst)
    out_valid && edge_res == EDGE_SLEEP |-> !awake)
    else $error("sleep edge reported while awake");

  // A granted write attaches the pin and needs an awake, powered partner.
  a_write_grant: assert property (@(posedge clk) disable iff (rst)
    out_valid && write_accepted |-> awake && line_high && tx_attached)
    else $error("write granted without awake powered attached link");

  a_write_no_edge: assert property (@(posedge clk) disable iff (rst)
    out_valid && write_accepted |-> edge_res == EDGE_NONE)
    else $error("write result carries an awake edge");

endmodule

bind console_link_awake_and_tx_gate clat_checker u_clat_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .awake          (awake),
  .line_high      (line_high),
  .tx_attached    (tx_attached),
  .edge_res       (edge_res),
  .write_accepted (write_accepted)
);
